[rtl/core/tccu_pkg.sv]
// ----------------------------------------------------------------------------
// tccu_pkg: shared types and constants of the text console cursor block
// Command format passed from the byte decoder to the result sequencer,
// sequencer states, result kinds and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package tccu_pkg;

  // Result kinds
  localparam logic [1:0] KIND_SERIAL = 2'd0;
  localparam logic [1:0] KIND_DRAW   = 2'd1;
  localparam logic [1:0] KIND_SCROLL = 2'd2;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMNS  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS     = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FG_COLOR = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BG_COLOR = 4'd3;

  // Reset values of the registers
  localparam logic [9:0]  COLUMNS_RESET = 10'd160;
  localparam logic [8:0]  ROWS_RESET    = 9'd50;
  localparam logic [31:0] FG_RESET      = 32'h00FF_FFFF;
  localparam logic [31:0] BG_RESET      = 32'h0000_0000;

  // Byte codes
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_BS    = 8'h08;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_QMARK = 8'h3F;

  // UTF-8 lead byte masks and patterns
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_PAT  = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_PAT  = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_PAT  = 8'hF0;

  // Command queue depth
  localparam int unsigned Q_DEPTH = 2;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_CR,
    OP_LF,
    OP_BS,
    OP_TAB,
    OP_DRAW
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [7:0]  raw_byte;
    logic [20:0] cp;
  } cmd_t;

  typedef struct packed {
    logic [9:0]  columns;
    logic [8:0]  rows;
    logic [31:0] fg;
    logic [31:0] bg;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DRAW,
    ST_SCROLL,
    ST_TAB_SER,
    ST_ERASE
  } state_t;

endpackage

`default_nettype wire

[rtl/core/tccu_front.sv]
// ----------------------------------------------------------------------------
// tccu_front: byte classifier and UTF-8 decoder
// Accepts one byte a cycle while the command queue is not full, tracks the
// multi-byte sequence state and pushes one command per byte into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module tccu_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [7:0]       char_byte,
  input  wire logic             q_full,
  output logic                  push,
  output tccu_pkg::cmd_t        push_cmd
);

  logic [20:0] acc;
  logic [20:0] acc_next;
  logic [1:0]  left;
  logic [1:0]  left_next;
  logic [20:0] acc_shift;

  assign in_stall  = q_full;
  assign push      = in_valid && !q_full;
  assign acc_shift = {acc[14:0], char_byte[5:0]};

  always_comb begin
    acc_next          = acc;
    left_next         = left;
    push_cmd.op       = tccu_pkg::OP_NONE;
    push_cmd.raw_byte = char_byte;
    push_cmd.cp       = 21'(char_byte);
    priority if (char_byte == tccu_pkg::CHAR_CR) begin
      push_cmd.op = tccu_pkg::OP_CR;
    end else if (char_byte == tccu_pkg::CHAR_LF) begin
      push_cmd.op = tccu_pkg::OP_LF;
    end else if (char_byte == tccu_pkg::CHAR_BS) begin
      push_cmd.op = tccu_pkg::OP_BS;
    end else if (char_byte == tccu_pkg::CHAR_TAB) begin
      push_cmd.op = tccu_pkg::OP_TAB;
    end else if (left == 2'd0) begin
      priority if (!char_byte[7]) begin
        push_cmd.op = tccu_pkg::OP_DRAW;
      end else if ((char_byte & tccu_pkg::LEAD2_MASK) == tccu_pkg::LEAD2_PAT) begin
        acc_next  = 21'(char_byte[4:0]);
        left_next = 2'd1;
      end else if ((char_byte & tccu_pkg::LEAD3_MASK) == tccu_pkg::LEAD3_PAT) begin
        acc_next  = 21'(char_byte[3:0]);
        left_next = 2'd2;
      end else if ((char_byte & tccu_pkg::LEAD4_MASK) == tccu_pkg::LEAD4_PAT) begin
        acc_next  = 21'(char_byte[2:0]);
        left_next = 2'd3;
      end else begin
        push_cmd.op = tccu_pkg::OP_DRAW;
        push_cmd.cp = 21'(tccu_pkg::CHAR_QMARK);
      end
    end else begin
      acc_next  = acc_shift;
      left_next = left - 2'd1;
      if (left == 2'd1) begin
        push_cmd.op = tccu_pkg::OP_DRAW;
        push_cmd.cp = acc_shift;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc  <= '0;
      left <= '0;
    end else if (push) begin
      acc  <= acc_next;
      left <= left_next;
    end
  end

endmodule

`default_nettype wire

[rtl/core/tccu_queue.sv]
// ----------------------------------------------------------------------------
// tccu_queue: short command queue
// Register FIFO between the decoder and the result sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module tccu_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire tccu_pkg::cmd_t push_cmd,
  input  wire logic           pop,
  output tccu_pkg::cmd_t      head,
  output logic                full,
  output logic                empty
);

  localparam int unsigned AW = (tccu_pkg::Q_DEPTH > 1) ? $clog2(tccu_pkg::Q_DEPTH) : 1;
  localparam int unsigned CW = $clog2(tccu_pkg::Q_DEPTH + 1);

  tccu_pkg::cmd_t entries [tccu_pkg::Q_DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  assign full  = (count == CW'(tccu_pkg::Q_DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (p == AW'(tccu_pkg::Q_DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/tccu_back.sv]
// ----------------------------------------------------------------------------
// tccu_back: result sequencer and cursor
// Pops commands, owns the cursor and emits one result per cycle into the
// output register, unless out_stall holds that register.
// ----------------------------------------------------------------------------
`default_nettype none

module tccu_back #(
  parameter int unsigned TAB_STOP = 4
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire tccu_pkg::cfg_t cfg,
  input  wire logic           q_empty,
  input  wire tccu_pkg::cmd_t head,
  output logic                pop,
  output logic                out_valid,
  input  wire logic           out_stall,
  output logic [1:0]          kind,
  output logic [7:0]          serial_byte,
  output logic [9:0]          column,
  output logic [8:0]          row,
  output logic [20:0]         code_point,
  output logic [31:0]         fg_color,
  output logic [31:0]         bg_color,
  output logic                last
);

  localparam int unsigned MW = $clog2(TAB_STOP);
  localparam int unsigned TW = $clog2(TAB_STOP + 1);

  tccu_pkg::state_t state;
  tccu_pkg::state_t state_next;

  logic [9:0]    col;
  logic [9:0]    col_next;
  logic [8:0]    cur_row;
  logic [8:0]    cur_row_next;
  logic [MW-1:0] col_mod;
  logic [MW-1:0] col_mod_next;
  logic [TW-1:0] tab_left;
  logic [TW-1:0] tab_left_next;
  logic [20:0]   cp_q;
  logic [20:0]   cp_q_next;

  logic          go;
  logic          emit;
  logic [1:0]    e_kind;
  logic [7:0]    e_serial;
  logic [9:0]    e_col;
  logic [8:0]    e_row;
  logic [20:0]   e_cp;
  logic [31:0]   e_fg;
  logic [31:0]   e_bg;
  logic          e_last;

  logic [9:0]    eff_cols;
  logic [8:0]    eff_rows;
  logic [9:0]    row_inc;
  logic [10:0]   col_inc;
  logic          need_scroll;
  logic          wrap;
  logic          more;
  logic [MW-1:0] mod_inc;
  logic [MW-1:0] mod_dec;

  assign go          = !out_valid || !out_stall;
  assign eff_cols    = (cfg.columns < 10'd4) ? 10'd4 : cfg.columns;
  assign eff_rows    = (cfg.rows == 9'd0) ? 9'd1 : cfg.rows;
  assign row_inc     = {1'b0, cur_row} + 10'd1;
  assign col_inc     = {1'b0, col} + 11'd1;
  assign need_scroll = (row_inc >= {1'b0, eff_rows});
  assign wrap        = (col_inc >= {1'b0, eff_cols});
  assign more        = (tab_left > TW'(1));
  assign mod_inc     = (col_mod == MW'(TAB_STOP - 1)) ? '0 : col_mod + MW'(1);
  assign mod_dec     = (col_mod == '0) ? MW'(TAB_STOP - 1) : col_mod - MW'(1);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      tccu_pkg::ST_IDLE: begin
        if (go && !q_empty) begin
          unique case (head.op)
            tccu_pkg::OP_LF:   state_next = need_scroll ? tccu_pkg::ST_SCROLL
                                                        : tccu_pkg::ST_IDLE;
            tccu_pkg::OP_BS:   state_next = (col != 10'd0) ? tccu_pkg::ST_ERASE
                                                           : tccu_pkg::ST_IDLE;
            tccu_pkg::OP_TAB:  state_next = tccu_pkg::ST_TAB_SER;
            tccu_pkg::OP_DRAW: state_next = tccu_pkg::ST_DRAW;
            default:           state_next = tccu_pkg::ST_IDLE;
          endcase
        end
      end
      tccu_pkg::ST_DRAW: begin
        if (go) begin
          if (wrap && need_scroll) begin
            state_next = tccu_pkg::ST_SCROLL;
          end else if (more) begin
            state_next = tccu_pkg::ST_TAB_SER;
          end else begin
            state_next = tccu_pkg::ST_IDLE;
          end
        end
      end
      tccu_pkg::ST_SCROLL: begin
        if (go) begin
          state_next = (tab_left != '0) ? tccu_pkg::ST_TAB_SER : tccu_pkg::ST_IDLE;
        end
      end
      tccu_pkg::ST_TAB_SER: begin
        if (go) begin
          state_next = tccu_pkg::ST_DRAW;
        end
      end
      tccu_pkg::ST_ERASE: begin
        if (go) begin
          state_next = tccu_pkg::ST_IDLE;
        end
      end
      default: state_next = tccu_pkg::ST_IDLE;
    endcase
  end

  // Emitted result and cursor updates
  always_comb begin
    pop           = 1'b0;
    emit          = 1'b0;
    e_kind        = tccu_pkg::KIND_SERIAL;
    e_serial      = '0;
    e_col         = '0;
    e_row         = '0;
    e_cp          = '0;
    e_fg          = '0;
    e_bg          = '0;
    e_last        = 1'b0;
    col_next      = col;
    cur_row_next  = cur_row;
    col_mod_next  = col_mod;
    tab_left_next = tab_left;
    cp_q_next     = cp_q;
    unique case (state)
      tccu_pkg::ST_IDLE: begin
        if (go && !q_empty) begin
          pop       = 1'b1;
          emit      = 1'b1;
          e_serial  = head.raw_byte;
          cp_q_next = head.cp;
          unique case (head.op)
            tccu_pkg::OP_CR: begin
              col_next     = '0;
              col_mod_next = '0;
              e_last       = 1'b1;
            end
            tccu_pkg::OP_LF: begin
              if (!need_scroll) begin
                col_next     = '0;
                col_mod_next = '0;
                cur_row_next = row_inc[8:0];
                e_last       = 1'b1;
              end
            end
            tccu_pkg::OP_BS: begin
              e_last = (col == 10'd0);
            end
            tccu_pkg::OP_TAB: begin
              tab_left_next = TW'(TAB_STOP) - TW'(col_mod);
              cp_q_next     = 21'(tccu_pkg::CHAR_SPACE);
            end
            tccu_pkg::OP_DRAW: begin
              e_last = 1'b0;
            end
            default: e_last = 1'b1;
          endcase
        end
      end
      tccu_pkg::ST_DRAW: begin
        if (go) begin
          emit   = 1'b1;
          e_kind = tccu_pkg::KIND_DRAW;
          e_col  = col;
          e_row  = cur_row;
          e_cp   = cp_q;
          e_fg   = cfg.fg;
          e_bg   = cfg.bg;
          e_last = !(wrap && need_scroll) && !more;
          if (tab_left != '0) begin
            tab_left_next = tab_left - TW'(1);
          end
          if (wrap) begin
            col_next     = '0;
            col_mod_next = '0;
            if (!need_scroll) begin
              cur_row_next = row_inc[8:0];
            end
          end else begin
            col_next     = col_inc[9:0];
            col_mod_next = mod_inc;
          end
        end
      end
      tccu_pkg::ST_SCROLL: begin
        if (go) begin
          emit         = 1'b1;
          e_kind       = tccu_pkg::KIND_SCROLL;
          e_bg         = cfg.bg;
          e_last       = (tab_left == '0);
          col_next     = '0;
          col_mod_next = '0;
          cur_row_next = eff_rows - 9'd1;
        end
      end
      tccu_pkg::ST_TAB_SER: begin
        if (go) begin
          emit     = 1'b1;
          e_serial = tccu_pkg::CHAR_SPACE;
        end
      end
      tccu_pkg::ST_ERASE: begin
        if (go) begin
          emit         = 1'b1;
          e_kind       = tccu_pkg::KIND_DRAW;
          e_col        = col - 10'd1;
          e_row        = cur_row;
          e_cp         = 21'(tccu_pkg::CHAR_SPACE);
          e_fg         = cfg.fg;
          e_bg         = cfg.bg;
          e_last       = 1'b1;
          col_next     = col - 10'd1;
          col_mod_next = mod_dec;
        end
      end
      default: emit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tccu_pkg::ST_IDLE;
      col       <= '0;
      cur_row   <= '0;
      col_mod   <= '0;
      tab_left  <= '0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      col      <= col_next;
      cur_row  <= cur_row_next;
      col_mod  <= col_mod_next;
      tab_left <= tab_left_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cp_q <= cp_q_next;
    if (emit) begin
      kind        <= e_kind;
      serial_byte <= e_serial;
      column      <= e_col;
      row         <= e_row;
      code_point  <= e_cp;
      fg_color    <= e_fg;
      bg_color    <= e_bg;
      last        <= e_last;
    end
  end

endmodule

`default_nettype wire

[rtl/core/text_console_cursor_utf8_top.sv]
// ----------------------------------------------------------------------------
// text_console_cursor_utf8_top: text console cursor with UTF-8 decoding
// Turns a byte stream into serial mirror, glyph draw and scroll requests.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake            Payload
//  -------  ---------  -------------------  ---------------------------------
//  in       sink       in_valid / in_stall  char_byte
//  out      source     out_valid/out_stall  kind, serial_byte, column, row,
//                                           code_point, fg_color, bg_color,
//                                           last
//  cfg      sink       cfg_valid/cfg_ready  cfg_index, cfg_data
//
//  Cycles: the decoder takes a byte per cycle into a two-entry command queue
//  while it has room; the sequencer emits one request per cycle unless the
//  output is stalled, and a byte yields 1 to 10 requests (typically 2).
//  Reset: synchronous, active high; clears cursor, decoder and queue and
//  loads the register defaults (160 columns, 50 rows, white on black).
//  Stalls: out_stall holds the output register; the sequencer waits, the
//  queue fills, and in_stall rises once the queue is full.
//  Configuration writes are always ready and take effect on the next cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_cursor_utf8_top #(
  parameter int unsigned TAB_STOP = 4
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // byte input
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [7:0]                         char_byte,
  // request output
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [1:0]                              kind,
  output logic [7:0]                              serial_byte,
  output logic [9:0]                              column,
  output logic [8:0]                              row,
  output logic [20:0]                             code_point,
  output logic [31:0]                             fg_color,
  output logic [31:0]                             bg_color,
  output logic                                    last,
  // register writes
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [tccu_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [31:0]                        cfg_data
);

  tccu_pkg::cfg_t cfg;
  tccu_pkg::cmd_t push_cmd;
  tccu_pkg::cmd_t head;
  logic           push;
  logic           pop;
  logic           q_full;
  logic           q_empty;

  // Register file: always ready, unknown indexes drop the write.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.columns <= tccu_pkg::COLUMNS_RESET;
      cfg.rows    <= tccu_pkg::ROWS_RESET;
      cfg.fg      <= tccu_pkg::FG_RESET;
      cfg.bg      <= tccu_pkg::BG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tccu_pkg::REG_COLUMNS:  cfg.columns <= cfg_data[9:0];
        tccu_pkg::REG_ROWS:     cfg.rows    <= cfg_data[8:0];
        tccu_pkg::REG_FG_COLOR: cfg.fg      <= cfg_data;
        tccu_pkg::REG_BG_COLOR: cfg.bg      <= cfg_data;
        default: cfg.fg <= cfg.fg;
      endcase
    end
  end

  // Front: classify each byte and advance the UTF-8 decoder.
  tccu_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .char_byte (char_byte),
    .q_full    (q_full),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  // Queue: decouple decoding from request emission.
  tccu_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .full     (q_full),
    .empty    (q_empty)
  );

  // Back: move the cursor and emit requests one per cycle unless the output stalls.
  tccu_back #(
    .TAB_STOP (TAB_STOP)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .q_empty     (q_empty),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .kind        (kind),
    .serial_byte (serial_byte),
    .column      (column),
    .row         (row),
    .code_point  (code_point),
    .fg_color    (fg_color),
    .bg_color    (bg_color),
    .last        (last)
  );

`ifndef NO_ASSERTIONS
  // Only draws carry a foreground color.
  a_fg_draw_only: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != tccu_pkg::KIND_DRAW |-> fg_color == 32'd0)
    else $error("foreground color on a non-draw request");

  // Serial mirrors carry no cell, glyph or color.
  a_serial_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == tccu_pkg::KIND_SERIAL |->
      column == 10'd0 && row == 9'd0 && code_point == 21'd0 && bg_color == 32'd0)
    else $error("serial request carries draw fields");

  // The queue is never both full and empty.
  a_queue_sane: assert property (@(posedge clk) disable iff (rst)
    !(q_full && q_empty))
    else $error("queue full and empty at once");

  // An accepted byte leaves a command waiting in the queue.
  a_push_lands: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> !q_empty)
    else $error("accepted byte lost before the sequencer");
`endif

endmodule

`default_nettype wire
